/* src/pngdf_pkg.sv */
// ----------------------------------------------------------------------------
// pngdf_pkg
// Shared types, codes and the CRC-32 byte update for the PNG chunk deframer.
// ----------------------------------------------------------------------------
package pngdf_pkg;

  // Result kinds
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_CHUNK  = 2'd1;
  localparam logic [1:0] KIND_BADSIG = 2'd2;
  localparam logic [1:0] KIND_TRUNC  = 2'd3;

  // CRC-32, reflected form
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  // Chunk type codes, big-endian characters
  localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
  localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

  // File signature bytes
  localparam logic [7:0] PNG_SIG [8] = '{
    8'h89, 8'h50, 8'h4e, 8'h47, 8'h0d, 8'h0a, 8'h1a, 8'h0a
  };

  typedef struct packed {
    logic [7:0] file_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  data_byte;
    logic [31:0] chunk_type;
    logic [31:0] chunk_length;
    logic [31:0] chunk_offset;
    logic        crc_ok;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [7:0]  bit_depth;
    logic [7:0]  color_type;
    logic [7:0]  interlace_method;
    logic        last_of_run;
  } out_item_t;

  // Records handed from the parser to the result buffer
  typedef struct packed {
    logic      push_a;
    logic      push_b;
    out_item_t rec_a;
    out_item_t rec_b;
  } push_t;

  // Free space in the result buffer
  typedef struct packed {
    logic space_one;
    logic space_two;
  } buf_stat_t;

  // One byte of the reflected CRC-32 (xor network, eight shift steps)
  function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

endpackage

/* src/pngdf_stream_if.sv */
// ----------------------------------------------------------------------------
// pngdf_stream_if
// Valid/ready stream channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface pngdf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/pngdf_in_reg.sv */
// ----------------------------------------------------------------------------
// pngdf_in_reg
// Input register: holds one byte until the parser takes it.
// ----------------------------------------------------------------------------
module pngdf_in_reg import pngdf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_item_t in_item,
  output logic     in_ready,
  input  logic     take,
  output logic     hold_valid,
  output in_item_t hold_item
);

  logic     vld_r, vld_nxt;
  in_item_t item_r;
  logic     accept;

  // Refill as the held byte leaves
  assign in_ready = !vld_r || take;
  assign accept   = in_valid && in_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign hold_valid = vld_r;
  assign hold_item  = item_r;

endmodule

/* src/pngdf_parser.sv */
// ----------------------------------------------------------------------------
// pngdf_parser
// Chunk walker: signature check, field capture, CRC and result records.
// ----------------------------------------------------------------------------
module pngdf_parser import pngdf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      hold_valid,
  input  in_item_t  hold_item,
  input  buf_stat_t stat,
  output logic      take,
  output push_t     push
);

  localparam logic [2:0] PH_SIG  = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_TYPE = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_CRC  = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;

  logic [2:0]  ph_r, ph_nxt;
  logic [31:0] fc_r, fc_nxt;
  logic [31:0] off_r, off_nxt;
  logic        sg_r, sg_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] typ_r, typ_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] stored_r, stored_nxt;
  logic [31:0] wid_r, wid_nxt;
  logic [31:0] hgt_r, hgt_nxt;
  logic [7:0]  dep_r, dep_nxt;
  logic [7:0]  col_r, col_nxt;
  logic [7:0]  ilc_r, ilc_nxt;

  logic [7:0]  b;
  logic [31:0] fc_inc;
  logic        emit_a;
  logic [1:0]  kind_a;
  logic [7:0]  data_a;
  logic        ok_a;
  logic        trunc;
  out_item_t   base;
  out_item_t   first_rec;
  out_item_t   trunc_rec;
  logic        fire;

  // Next state and result records for the held byte
  always_comb begin
    b          = hold_item.file_byte;
    fc_inc     = fc_r + 32'd1;
    ph_nxt     = ph_r;
    fc_nxt     = fc_r;
    off_nxt    = off_r + 32'd1;
    sg_nxt     = sg_r;
    len_nxt    = len_r;
    typ_nxt    = typ_r;
    start_nxt  = start_r;
    crc_nxt    = crc_r;
    stored_nxt = stored_r;
    wid_nxt    = wid_r;
    hgt_nxt    = hgt_r;
    dep_nxt    = dep_r;
    col_nxt    = col_r;
    ilc_nxt    = ilc_r;
    emit_a     = 1'b0;
    kind_a     = KIND_DATA;
    data_a     = 8'd0;
    ok_a       = 1'b0;

    unique case (ph_r)
      PH_SIG: begin
        sg_nxt = sg_r && (b == PNG_SIG[fc_r[2:0]]);
        fc_nxt = fc_inc;
        if (fc_r[2:0] == 3'd7) begin
          fc_nxt = 32'd0;
          if (sg_nxt) begin
            ph_nxt = PH_LEN;
          end else begin
            emit_a = 1'b1;
            kind_a = KIND_BADSIG;
            ph_nxt = PH_DONE;
          end
        end
      end
      PH_LEN: begin
        if (fc_r == 32'd0) begin
          start_nxt = off_r;
        end
        len_nxt = {len_r[23:0], b};
        fc_nxt  = fc_inc;
        if (fc_r[1:0] == 2'd3) begin
          fc_nxt  = 32'd0;
          crc_nxt = CRC_ONES;
          ph_nxt  = PH_TYPE;
        end
      end
      PH_TYPE: begin
        crc_nxt = crc32_byte(crc_r, b);
        typ_nxt = {typ_r[23:0], b};
        fc_nxt  = fc_inc;
        if (fc_r[1:0] == 2'd3) begin
          fc_nxt = 32'd0;
          ph_nxt = (len_r != 32'd0) ? PH_DATA : PH_CRC;
        end
      end
      PH_DATA: begin
        crc_nxt = crc32_byte(crc_r, b);
        // Capture header fields from the leading bytes of IHDR
        if (typ_r == TYPE_IHDR) begin
          if (fc_r < 32'd4) begin
            wid_nxt = {wid_r[23:0], b};
          end else if (fc_r < 32'd8) begin
            hgt_nxt = {hgt_r[23:0], b};
          end else if (fc_r == 32'd8) begin
            dep_nxt = b;
          end else if (fc_r == 32'd9) begin
            col_nxt = b;
          end else if (fc_r == 32'd12) begin
            ilc_nxt = b;
          end
        end else if (typ_r == TYPE_IDAT) begin
          emit_a = 1'b1;
          kind_a = KIND_DATA;
          data_a = b;
        end
        fc_nxt = fc_inc;
        if (fc_inc == len_r) begin
          fc_nxt = 32'd0;
          ph_nxt = PH_CRC;
        end
      end
      PH_CRC: begin
        stored_nxt = {stored_r[23:0], b};
        fc_nxt     = fc_inc;
        if (fc_r[1:0] == 2'd3) begin
          fc_nxt = 32'd0;
          emit_a = 1'b1;
          kind_a = KIND_CHUNK;
          ok_a   = ((crc_r ^ CRC_ONES) == stored_nxt);
          ph_nxt = (typ_r == TYPE_IEND) ? PH_DONE : PH_LEN;
        end
      end
      PH_DONE: begin
        fc_nxt = fc_r;
      end
      default: begin
        ph_nxt = ph_r;
      end
    endcase

    trunc = hold_item.last_byte && (ph_nxt != PH_DONE);

    // Records carry the register values after this byte
    base.result_kind      = KIND_DATA;
    base.data_byte        = 8'd0;
    base.chunk_type       = typ_nxt;
    base.chunk_length     = len_nxt;
    base.chunk_offset     = start_nxt;
    base.crc_ok           = 1'b0;
    base.image_width      = wid_nxt;
    base.image_height     = hgt_nxt;
    base.bit_depth        = dep_nxt;
    base.color_type       = col_nxt;
    base.interlace_method = ilc_nxt;
    base.last_of_run      = 1'b1;

    first_rec             = base;
    first_rec.result_kind = kind_a;
    first_rec.data_byte   = data_a;
    first_rec.crc_ok      = ok_a;
    first_rec.last_of_run = !trunc;

    trunc_rec             = base;
    trunc_rec.result_kind = KIND_TRUNC;

    // End of file: back to reset values for the next file
    if (hold_item.last_byte) begin
      ph_nxt     = PH_SIG;
      fc_nxt     = 32'd0;
      off_nxt    = 32'd0;
      sg_nxt     = 1'b1;
      len_nxt    = 32'd0;
      typ_nxt    = 32'd0;
      start_nxt  = 32'd0;
      crc_nxt    = CRC_ONES;
      stored_nxt = 32'd0;
      wid_nxt    = 32'd0;
      hgt_nxt    = 32'd0;
      dep_nxt    = 8'd0;
      col_nxt    = 8'd0;
      ilc_nxt    = 8'd0;
    end
  end

  // Advance only when the result buffer has room for every record
  always_comb begin
    priority if (emit_a && trunc) begin
      fire = hold_valid && stat.space_two;
    end else if (emit_a || trunc) begin
      fire = hold_valid && stat.space_one;
    end else begin
      fire = hold_valid;
    end
  end

  assign take        = fire;
  assign push.push_a = fire && (emit_a || trunc);
  assign push.push_b = fire && emit_a && trunc;
  assign push.rec_a  = emit_a ? first_rec : trunc_rec;
  assign push.rec_b  = trunc_rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r     <= PH_SIG;
      fc_r     <= 32'd0;
      off_r    <= 32'd0;
      sg_r     <= 1'b1;
      len_r    <= 32'd0;
      typ_r    <= 32'd0;
      start_r  <= 32'd0;
      crc_r    <= CRC_ONES;
      stored_r <= 32'd0;
      wid_r    <= 32'd0;
      hgt_r    <= 32'd0;
      dep_r    <= 8'd0;
      col_r    <= 8'd0;
      ilc_r    <= 8'd0;
    end else if (fire) begin
      ph_r     <= ph_nxt;
      fc_r     <= fc_nxt;
      off_r    <= off_nxt;
      sg_r     <= sg_nxt;
      len_r    <= len_nxt;
      typ_r    <= typ_nxt;
      start_r  <= start_nxt;
      crc_r    <= crc_nxt;
      stored_r <= stored_nxt;
      wid_r    <= wid_nxt;
      hgt_r    <= hgt_nxt;
      dep_r    <= dep_nxt;
      col_r    <= col_nxt;
      ilc_r    <= ilc_nxt;
    end
  end

  // A second record is always the truncation report
  a_second_is_trunc: assert property (@(posedge clk) disable iff (!rst_n)
    push.push_b |-> push.rec_b.result_kind == KIND_TRUNC)
    else $error("second record of a byte is not a truncation report");

  // Counters outside the data phase never leave the signature range
  a_fc_small: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r != PH_DATA) |-> (fc_r < 32'd8))
    else $error("field count out of range outside data phase");

  // Phase stays among the defined codes
  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    ph_r <= PH_DONE)
    else $error("parse phase holds an undefined code");

endmodule

/* src/pngdf_out_buf.sv */
// ----------------------------------------------------------------------------
// pngdf_out_buf
// Two-entry result buffer; takes up to two records per cycle, emits one when the sink is ready.
// ----------------------------------------------------------------------------
module pngdf_out_buf import pngdf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  push_t     push,
  output buf_stat_t stat,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      out_ready
);

  out_item_t  slot_r [2];
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_ptr;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_item  = slot_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign wr_ptr    = rd_ptr_r ^ cnt_r[0];

  // Space is judged on the registered count alone
  assign stat.space_one = (cnt_r != 2'd2);
  assign stat.space_two = (cnt_r == 2'd0);

  always_comb begin
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push.push_a} + {1'b0, push.push_b} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Write records in order behind the oldest entry
  always_ff @(posedge clk) begin
    if (push.push_a) begin
      slot_r[wr_ptr] <= push.rec_a;
    end
    if (push.push_b) begin
      slot_r[~wr_ptr] <= push.rec_b;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.push_a |-> cnt_r != 2'd2)
    else $error("record pushed into a full buffer");

  a_pair_empty: assert property (@(posedge clk) disable iff (!rst_n)
    push.push_b |-> (push.push_a && cnt_r == 2'd0))
    else $error("record pair pushed without two free entries");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("buffer count out of range");

endmodule

/* src/png_chunk_deframer_crc32_core.sv */
// ----------------------------------------------------------------------------
// png_chunk_deframer_crc32_core
// PNG byte stream deframer: signature check, chunk walk, IDAT forwarding,
// IHDR capture and per-chunk CRC-32 check.
// ----------------------------------------------------------------------------
//  channel  dir  payload                      transaction
//  in_if    in   file_byte, last_byte         one file byte
//  out_if   out  result record (12 fields)    one result record
//
//  One byte per cycle while the result buffer has room; a byte is held in the
//  input register before its records enter the result buffer. A byte giving
//  two records (IDAT byte or chunk record plus a truncation report) waits for
//  an empty buffer while the sink drains; a full buffer holds back any record
//  even as the sink pops. Synchronous reset clears both stages; ready depends
//  only on registers, so out_if stalls reach in_if in the following cycle.
// ----------------------------------------------------------------------------
module png_chunk_deframer_crc32_core import pngdf_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  pngdf_stream_if.sink   in_if,
  pngdf_stream_if.source out_if
);

  logic      in_ready;
  logic      hold_valid;
  in_item_t  hold_item;
  logic      take;
  push_t     push;
  buf_stat_t stat;
  in_item_t  in_item;
  out_item_t out_item;
  logic      out_valid;

  assign in_item.file_byte = in_if.data.file_byte;
  assign in_item.last_byte = in_if.data.last_byte;
  assign in_if.ready       = in_ready;

  // Input register
  pngdf_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_item    (in_item),
    .in_ready   (in_ready),
    .take       (take),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  // Chunk parser
  pngdf_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .hold_valid (hold_valid),
    .hold_item  (hold_item),
    .stat       (stat),
    .take       (take),
    .push       (push)
  );

  // Result buffer
  pngdf_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_ready (out_if.ready)
  );

  assign out_if.valid = out_valid;
  assign out_if.data  = out_item;

endmodule

/* bench/png_chunk_deframer_crc32_core_tb.sv */
// ----------------------------------------------------------------------------
// png_chunk_deframer_crc32_core_tb
// Feeds the deframer short directed byte runs and then generated PNG files
// (well-formed, CRC-damaged, truncated, bad signature, plain noise) under
// random idling on both channels. Every result record is checked field by
// field against the bench's behavioral deframer or the directed row's record.
// ----------------------------------------------------------------------------
module png_chunk_deframer_crc32_core_tb;
  import pngdf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS_TARGET = 1200;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 20;
  localparam int N_DIRECTED   = 22;

  typedef enum logic [2:0] {
    SCAN_SIG, SCAN_LEN, SCAN_TYPE, SCAN_DATA, SCAN_CRC, SCAN_DONE
  } scan_phase_t;

  typedef struct packed {
    logic [7:0] b;
    logic       lst;
    logic       typed;
    logic [1:0] kind;
  } stim_row_t;

  logic clk;
  logic rst_n;

  pngdf_stream_if #(.payload_t(in_item_t))  in_ch ();
  pngdf_stream_if #(.payload_t(out_item_t)) out_ch ();

  png_chunk_deframer_crc32_core DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  // Bench-side deframer state
  scan_phase_t phase;
  logic [31:0] fld_cnt;
  logic [31:0] file_pos;
  logic        sig_ok;
  logic [31:0] chunk_len;
  logic [31:0] chunk_code;
  logic [31:0] chunk_start;
  logic [31:0] crc_acc;
  logic [31:0] crc_rx;
  logic [31:0] img_w;
  logic [31:0] img_h;
  logic [7:0]  img_depth;
  logic [7:0]  img_color;
  logic [7:0]  img_ilace;

  logic [31:0] crc_lut [256];
  out_item_t   fresh_records [$];
  out_item_t   pending_records [$];
  logic [7:0]  file_bytes [$];

  int  mismatch_count = 0;
  int  bytes_accepted = 0;
  int  cycle_count = 0;
  int  gap_pct = 10;
  bit  quiet_tail = 0;

  stim_row_t directed_rows [N_DIRECTED] = '{
    // single byte file right after reset: truncation, all fields clear
    '{8'h00, 1'b1, 1'b1, KIND_TRUNC},
    // all-ones signature: rejected on the eighth byte
    '{8'hff, 1'b0, 1'b0, KIND_DATA}, '{8'hff, 1'b0, 1'b0, KIND_DATA},
    '{8'hff, 1'b0, 1'b0, KIND_DATA}, '{8'hff, 1'b0, 1'b0, KIND_DATA},
    '{8'hff, 1'b0, 1'b0, KIND_DATA}, '{8'hff, 1'b0, 1'b0, KIND_DATA},
    '{8'hff, 1'b0, 1'b0, KIND_DATA}, '{8'hff, 1'b0, 1'b1, KIND_BADSIG},
    // bytes after a rejected signature are dropped, last one restarts
    '{8'h00, 1'b0, 1'b0, KIND_DATA}, '{8'hff, 1'b1, 1'b0, KIND_DATA},
    // good signature, then the file ends inside a length field
    '{8'h89, 1'b0, 1'b0, KIND_DATA}, '{8'h50, 1'b0, 1'b0, KIND_DATA},
    '{8'h4e, 1'b0, 1'b0, KIND_DATA}, '{8'h47, 1'b0, 1'b0, KIND_DATA},
    '{8'h0d, 1'b0, 1'b0, KIND_DATA}, '{8'h0a, 1'b0, 1'b0, KIND_DATA},
    '{8'h1a, 1'b0, 1'b0, KIND_DATA}, '{8'h0a, 1'b0, 1'b0, KIND_DATA},
    '{8'h00, 1'b0, 1'b0, KIND_DATA}, '{8'hff, 1'b0, 1'b0, KIND_DATA},
    '{8'h00, 1'b1, 1'b0, KIND_DATA}
  };

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle count and run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: run limit reached, %0d records still due",
               $time, pending_records.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic clear_parse_state();
    phase       = SCAN_SIG;
    fld_cnt     = '0;
    file_pos    = '0;
    sig_ok      = 1'b1;
    chunk_len   = '0;
    chunk_code  = '0;
    chunk_start = '0;
    crc_acc     = CRC_ONES;
    crc_rx      = '0;
    img_w       = '0;
    img_h       = '0;
    img_depth   = '0;
    img_color   = '0;
    img_ilace   = '0;
  endtask

  function automatic out_item_t snapshot(logic [1:0] kind, logic [7:0] db, logic ok);
    out_item_t r;
    r.result_kind      = kind;
    r.data_byte        = db;
    r.chunk_type       = chunk_code;
    r.chunk_length     = chunk_len;
    r.chunk_offset     = chunk_start;
    r.crc_ok           = ok;
    r.image_width      = img_w;
    r.image_height     = img_h;
    r.bit_depth        = img_depth;
    r.color_type       = img_color;
    r.interlace_method = img_ilace;
    r.last_of_run      = 1'b0;
    return r;
  endfunction

  // Advance the bench deframer by one file byte; records land in fresh_records
  task automatic deframe_byte(input logic [7:0] b, input logic lst);
    fresh_records.delete();
    unique case (phase)
      SCAN_SIG: begin
        if (b != PNG_SIG[fld_cnt[2:0]]) sig_ok = 1'b0;
        fld_cnt++;
        if (fld_cnt >= 8) begin
          fld_cnt = '0;
          if (sig_ok) begin
            phase = SCAN_LEN;
          end else begin
            fresh_records.insert(fresh_records.size(),
                                 snapshot(KIND_BADSIG, 8'h00, 1'b0));
            phase = SCAN_DONE;
          end
        end
      end
      SCAN_LEN: begin
        if (fld_cnt == 0) chunk_start = file_pos;
        chunk_len = {chunk_len[23:0], b};
        fld_cnt++;
        if (fld_cnt >= 4) begin
          fld_cnt = '0;
          crc_acc = CRC_ONES;
          phase   = SCAN_TYPE;
        end
      end
      SCAN_TYPE: begin
        crc_acc    = (crc_acc >> 8) ^ crc_lut[crc_acc[7:0] ^ b];
        chunk_code = {chunk_code[23:0], b};
        fld_cnt++;
        if (fld_cnt >= 4) begin
          fld_cnt = '0;
          phase   = (chunk_len != 0) ? SCAN_DATA : SCAN_CRC;
        end
      end
      SCAN_DATA: begin
        crc_acc = (crc_acc >> 8) ^ crc_lut[crc_acc[7:0] ^ b];
        if (chunk_code == TYPE_IHDR) begin
          if (fld_cnt < 4)       img_w = {img_w[23:0], b};
          else if (fld_cnt < 8)  img_h = {img_h[23:0], b};
          else if (fld_cnt == 8) img_depth = b;
          else if (fld_cnt == 9) img_color = b;
          else if (fld_cnt == 12) img_ilace = b;
        end else if (chunk_code == TYPE_IDAT) begin
          fresh_records.insert(fresh_records.size(), snapshot(KIND_DATA, b, 1'b0));
        end
        fld_cnt++;
        if (fld_cnt >= chunk_len) begin
          fld_cnt = '0;
          phase   = SCAN_CRC;
        end
      end
      SCAN_CRC: begin
        crc_rx = {crc_rx[23:0], b};
        fld_cnt++;
        if (fld_cnt >= 4) begin
          fld_cnt = '0;
          fresh_records.insert(fresh_records.size(),
                               snapshot(KIND_CHUNK, 8'h00, (crc_acc ^ CRC_ONES) == crc_rx));
          phase = (chunk_code == TYPE_IEND) ? SCAN_DONE : SCAN_LEN;
        end
      end
      default: ;
    endcase
    file_pos++;
    // End of file: report truncation unless the file closed, then restart
    if (lst) begin
      if (phase != SCAN_DONE)
        fresh_records.insert(fresh_records.size(), snapshot(KIND_TRUNC, 8'h00, 1'b0));
      clear_parse_state();
    end
    if (fresh_records.size() > 0)
      fresh_records[fresh_records.size() - 1].last_of_run = 1'b1;
  endtask

  // Offer one byte, hold it until the transaction, then record what it causes
  task automatic send_byte(input logic [7:0] b, input logic lst,
                           input logic typed, input logic [1:0] typed_kind);
    out_item_t want;
    if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
      repeat ($urandom_range(1, 19)) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{file_byte: b, last_byte: lst};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_accepted++;
    deframe_byte(b, lst);
    if (typed) begin
      want = '0;
      want.result_kind = typed_kind;
      want.last_of_run = 1'b1;
      pending_records.insert(pending_records.size(), want);
    end else begin
      foreach (fresh_records[i])
        pending_records.insert(pending_records.size(), fresh_records[i]);
    end
  endtask

  // Append one chunk with a correct or damaged CRC to the file under construction
  task automatic append_chunk(input logic [31:0] code, input int len, input bit bad_crc);
    logic [31:0] c;
    logic [31:0] l;
    logic [7:0]  d;
    int          flip;
    c = CRC_ONES;
    l = 32'(len);
    for (int i = 3; i >= 0; i--) file_bytes.insert(file_bytes.size(), l[8*i +: 8]);
    for (int i = 3; i >= 0; i--) begin
      d = code[8*i +: 8];
      c = (c >> 8) ^ crc_lut[c[7:0] ^ d];
      file_bytes.insert(file_bytes.size(), d);
    end
    for (int i = 0; i < len; i++) begin
      d = 8'($urandom);
      c = (c >> 8) ^ crc_lut[c[7:0] ^ d];
      file_bytes.insert(file_bytes.size(), d);
    end
    c = c ^ CRC_ONES;
    // Damage: flip one stored CRC bit
    if (bad_crc) begin
      flip    = $urandom_range(0, 31);
      c[flip] = ~c[flip];
    end
    for (int i = 3; i >= 0; i--) file_bytes.insert(file_bytes.size(), c[8*i +: 8]);
  endtask

  // Build one random file: mostly well-formed, the rest damaged or noise
  task automatic build_file();
    int style;
    int pick;
    int cut;
    file_bytes.delete();
    style = $urandom_range(0, 99);
    if (style < 8) begin
      repeat ($urandom_range(1, 24)) file_bytes.insert(file_bytes.size(), 8'($urandom));
      return;
    end
    foreach (PNG_SIG[i]) file_bytes.insert(file_bytes.size(), PNG_SIG[i]);
    if ($urandom_range(0, 19) == 0)
      file_bytes[$urandom_range(0, 7)] ^= 8'($urandom_range(1, 255));
    append_chunk(TYPE_IHDR, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : 13,
                 $urandom_range(0, 9) == 0);
    repeat ($urandom_range(0, 3)) begin
      pick = $urandom_range(0, 9);
      if (pick < 5)
        append_chunk(TYPE_IDAT, $urandom_range(0, 10), $urandom_range(0, 9) == 0);
      else if (pick < 6)
        append_chunk(TYPE_IHDR, $urandom_range(0, 16), 1'b0);
      else
        append_chunk($urandom, $urandom_range(0, 5), $urandom_range(0, 9) == 0);
    end
    if ($urandom_range(0, 19) == 0) begin
      // unfinished chunk with an arbitrary length field
      repeat ($urandom_range(4, 12)) file_bytes.insert(file_bytes.size(), 8'($urandom));
      return;
    end
    append_chunk(TYPE_IEND, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0,
                 $urandom_range(0, 9) == 0);
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3)) file_bytes.insert(file_bytes.size(), 8'($urandom));
    if (style < 22) begin
      cut = $urandom_range(1, file_bytes.size() - 1);
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
  endtask

  // Receiver: random stall bursts, long hold-offs, none near the end
  initial begin
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (bytes_accepted >= HOLD_CYCLES && bytes_accepted < HOLD_CYCLES + 50 &&
          !quiet_tail && out_ch.ready) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) begin
          @(negedge clk);
          out_ch.ready <= 1'b0;
        end
        // let the backlog move before any further hold-off can start
        repeat (60) begin
          @(negedge clk);
          out_ch.ready <= 1'b1;
        end
      end else if (!quiet_tail && (cycle_count / 512) % 3 != 0 &&
                   $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19) - 1) begin
          @(negedge clk);
          out_ch.ready <= 1'b0;
        end
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0h got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each result transaction against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_records.size() == 0) begin
        $display("%0t ns: unexpected record, kind %0d expected none got %0h",
                 $time, got.result_kind, got);
        mismatch_count++;
      end else begin
        want = pending_records.pop_front();
        check_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
        check_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
        check_field("chunk_type", want.chunk_type, got.chunk_type);
        check_field("chunk_length", want.chunk_length, got.chunk_length);
        check_field("chunk_offset", want.chunk_offset, got.chunk_offset);
        check_field("crc_ok", 32'(want.crc_ok), 32'(got.crc_ok));
        check_field("image_width", want.image_width, got.image_width);
        check_field("image_height", want.image_height, got.image_height);
        check_field("bit_depth", 32'(want.bit_depth), 32'(got.bit_depth));
        check_field("color_type", 32'(want.color_type), 32'(got.color_type));
        check_field("interlace_method", 32'(want.interlace_method),
                    32'(got.interlace_method));
        check_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
      end
    end
  end

  // Stimulus
  initial begin
    logic [31:0] c;
    int          drain;
    for (int i = 0; i < 256; i++) begin
      c = 32'(i);
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      crc_lut[i] = c;
    end
    clear_parse_state();
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    rst_n       = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows
    foreach (directed_rows[i])
      send_byte(directed_rows[i].b, directed_rows[i].lst,
                directed_rows[i].typed, directed_rows[i].kind);

    // Random files; the tail runs without idling
    while (bytes_accepted < ITEMS_TARGET) begin
      if (bytes_accepted >= ITEMS_TARGET * 5 / 6) quiet_tail = 1'b1;
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 8;
        default: gap_pct = 30;
      endcase
      build_file();
      foreach (file_bytes[i])
        send_byte(file_bytes[i], i == file_bytes.size() - 1, 1'b0, KIND_DATA);
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    // Drain, then watch for stray records before the verdict
    while (pending_records.size() > 0) @(posedge clk);
    drain = 0;
    while (drain < DRAIN_CYCLES) begin
      @(posedge clk);
      drain++;
    end
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* png_chunk_deframer_crc32_core.f */
src/pngdf_pkg.sv
src/pngdf_stream_if.sv
src/pngdf_in_reg.sv
src/pngdf_parser.sv
src/pngdf_out_buf.sv
src/png_chunk_deframer_crc32_core.sv
bench/png_chunk_deframer_crc32_core_tb.sv
